// ----- hdl/lpht_pkg.sv -----
// Shared types and constants of the linear-probing hash table.
package lpht_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned HASH_W       = 32;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP    = 2'd0,
    OP_INSERT    = 2'd1,
    OP_OVERWRITE = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_PROBE
  } fsm_e;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] typ;
  } slot_t;

endpackage

// ----- hdl/lpht_start_slot.sv -----
// Reduces a key hash to its start slot, the hash modulo the table capacity.
module lpht_start_slot #(
  parameter int unsigned CAPACITY = lpht_pkg::DEF_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [lpht_pkg::HASH_W-1:0]   hash_i,
  output logic                          done_o,
  output logic [$clog2(CAPACITY)-1:0]   slot_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
    logic [IDX_W-1:0] slot_q;
    logic             done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= load_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        slot_q <= hash_i[IDX_W-1:0];
      end
    end

    assign done_o = done_q;
    assign slot_o = slot_q;
  end else begin : g_recip
    // The truncated reciprocal gives the quotient or one less, so one
    // conditional subtraction finishes the remainder.
    localparam int unsigned SHIFT = lpht_pkg::HASH_W - 1 + IDX_W;
    localparam logic [63:0] RECIP_W = (64'd1 << SHIFT) / 64'(CAPACITY);
    localparam logic [lpht_pkg::HASH_W-1:0] RECIP = lpht_pkg::HASH_W'(RECIP_W);
    localparam logic [lpht_pkg::HASH_W-1:0] CAP_H = lpht_pkg::HASH_W'(CAPACITY);

    logic [lpht_pkg::HASH_W-1:0]   hash_q;
    logic [lpht_pkg::HASH_W-1:0]   quot_q;
    logic [lpht_pkg::HASH_W-1:0]   rem_q;
    logic [IDX_W-1:0]              slot_q;
    logic [2*lpht_pkg::HASH_W-1:0] prod;
    logic [lpht_pkg::HASH_W-1:0]   back;
    logic [lpht_pkg::HASH_W-1:0]   fixed;
    logic [1:0]                    stage_q;
    logic                          done_q;

    always_comb begin
      prod  = {{lpht_pkg::HASH_W{1'b0}}, hash_i} * {{lpht_pkg::HASH_W{1'b0}}, RECIP};
      back  = quot_q * CAP_H;
      fixed = (rem_q >= CAP_H) ? rem_q - CAP_H : rem_q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= '0;
        done_q  <= 1'b0;
      end else begin
        stage_q <= {stage_q[0], load_i};
        done_q  <= stage_q[1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        hash_q <= hash_i;
        quot_q <= lpht_pkg::HASH_W'(prod >> SHIFT);
      end
      if (stage_q[0]) begin
        rem_q <= hash_q - back;
      end
      if (stage_q[1]) begin
        slot_q <= fixed[IDX_W-1:0];
      end
    end

    assign done_o = done_q;
    assign slot_o = slot_q;
  end

endmodule

// ----- hdl/lpht_slot_ram.sv -----
// Single-port slot memory with a registered read port.
module lpht_slot_ram #(
  parameter int unsigned CAPACITY = lpht_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [$clog2(CAPACITY)-1:0] addr_i,
  input  lpht_pkg::slot_t             wdata_i,
  output lpht_pkg::slot_t             rdata_o
);

  lpht_pkg::slot_t mem_q [CAPACITY];
  lpht_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/linear_probe_hash_table.sv -----
// Top level of the linear-probing hash table: probe sequencer around the slot memory.
//
// Channel   Direction  Handshake                       Payload
// request   in         start high and busy low         operation_i, key_i, key_hash_i,
//                                                      value_in_i, type_in_i
// result    out        done_o high for one cycle       status_o, value_out_o, type_out_o
//
// After reset a clearing pass writes every slot empty, with busy high throughout.
// A request keeps busy high through the start-slot reduction and every slot probed
// (1 to CAPACITY); a capacity that is not a power of two adds registered reciprocal
// quotient, remainder and correction steps. The slot memory is single-port and sets
// the pace: one slot is read per cycle. The result appears the cycle after the last
// probe, and an unused operation code answers in the cycle after its acceptance.
module linear_probe_hash_table #(
  parameter int unsigned CAPACITY = lpht_pkg::DEF_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::HASH_W-1:0]   key_hash_i,
  input  logic [lpht_pkg::DATA_W-1:0]   value_in_i,
  input  logic [lpht_pkg::DATA_W-1:0]   type_in_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [lpht_pkg::DATA_W-1:0]   value_out_o,
  output logic [lpht_pkg::DATA_W-1:0]   type_out_o
);

  localparam int unsigned      IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(CAPACITY - 1);

  lpht_pkg::fsm_e              state_q, state_d;
  lpht_pkg::op_e               op_q;
  logic [lpht_pkg::KEY_W-1:0]  key_q;
  logic [lpht_pkg::HASH_W-1:0] hash_q;
  logic [lpht_pkg::DATA_W-1:0] val_q;
  logic [lpht_pkg::DATA_W-1:0] typ_q;
  logic [IDX_W-1:0]            ptr_q, ptr_d;
  logic [IDX_W-1:0]            cnt_q, cnt_d;
  logic [IDX_W-1:0]            ptr_next;
  logic                        done_q, done_d;
  lpht_pkg::status_e           status_q, status_d;
  logic [lpht_pkg::DATA_W-1:0] vout_q, vout_d;
  logic [lpht_pkg::DATA_W-1:0] tout_q, tout_d;
  logic                        accept;
  logic                        mod_load;
  logic                        mod_done;
  logic [IDX_W-1:0]            mod_slot;
  logic                        ram_we;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_addr;
  lpht_pkg::slot_t             ram_wdata;
  lpht_pkg::slot_t             ram_rdata;

  lpht_start_slot #(
    .CAPACITY(CAPACITY)
  ) u_start_slot (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(mod_load),
    .hash_i(key_hash_i),
    .done_o(mod_done),
    .slot_o(mod_slot)
  );

  lpht_slot_ram #(
    .CAPACITY(CAPACITY)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign ptr_next = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    vout_d    = vout_q;
    tout_d    = tout_q;
    accept    = 1'b0;
    mod_load  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = ptr_q;
    ram_wdata = '{valid: 1'b1, key: key_q, hash: hash_q, value: val_q, typ: typ_q};
    unique case (state_q)
      lpht_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (ptr_q == LAST) begin
          ptr_d   = '0;
          state_d = lpht_pkg::S_IDLE;
        end else begin
          ptr_d = ptr_next;
        end
      end
      lpht_pkg::S_IDLE: begin
        if (start) begin
          accept = 1'b1;
          unique case (operation_i) inside
            lpht_pkg::OP_LOOKUP, lpht_pkg::OP_INSERT, lpht_pkg::OP_OVERWRITE: begin
              mod_load = 1'b1;
              state_d  = lpht_pkg::S_REDUCE;
            end
            default: begin
              done_d   = 1'b1;
              status_d = lpht_pkg::ST_ABSENT;
              vout_d   = '0;
              tout_d   = '0;
            end
          endcase
        end
      end
      lpht_pkg::S_REDUCE: begin
        if (mod_done) begin
          ram_re   = 1'b1;
          ram_addr = mod_slot;
          ptr_d    = mod_slot;
          cnt_d    = '0;
          state_d  = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        vout_d = '0;
        tout_d = '0;
        if (op_q == lpht_pkg::OP_LOOKUP) begin
          if (!ram_rdata.valid) begin
            done_d   = 1'b1;
            status_d = lpht_pkg::ST_ABSENT;
          end else if (ram_rdata.hash == hash_q && ram_rdata.key == key_q) begin
            done_d   = 1'b1;
            status_d = lpht_pkg::ST_OK;
            vout_d   = ram_rdata.value;
            tout_d   = ram_rdata.typ;
          end else if (cnt_q == LAST) begin
            done_d   = 1'b1;
            status_d = lpht_pkg::ST_ABSENT;
          end
        end else begin
          if (!ram_rdata.valid || ram_rdata.key == key_q) begin
            done_d = 1'b1;
            if (ram_rdata.valid && op_q == lpht_pkg::OP_INSERT) begin
              status_d = lpht_pkg::ST_PRESENT;
            end else begin
              ram_we   = 1'b1;
              status_d = lpht_pkg::ST_OK;
            end
          end else if (cnt_q == LAST) begin
            done_d   = 1'b1;
            status_d = lpht_pkg::ST_FULL;
          end
        end
        if (done_d) begin
          state_d = lpht_pkg::S_IDLE;
        end else begin
          ram_re   = 1'b1;
          ram_addr = ptr_next;
          ptr_d    = ptr_next;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::S_CLEAR;
      ptr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    vout_q   <= vout_d;
    tout_q   <= tout_d;
    if (accept) begin
      op_q   <= lpht_pkg::op_e'(operation_i);
      key_q  <= key_i;
      hash_q <= key_hash_i;
      val_q  <= value_in_i;
      typ_q  <= type_in_i;
    end
  end

  assign busy        = (state_q != lpht_pkg::S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign value_out_o = vout_q;
  assign type_out_o  = tout_q;

endmodule

// ----- hdl/lpht_checker.sv -----
// Port-level assertions for the hash table and the bind that attaches them.
module lpht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    operation_i,
  input logic                          done_o,
  input logic [1:0]                    status_o,
  input logic [lpht_pkg::DATA_W-1:0]   value_out_o,
  input logic [lpht_pkg::DATA_W-1:0]   type_out_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("Accepted transaction neither in progress nor answered.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while the table is still busy.");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != 2'(lpht_pkg::ST_OK)) |-> (value_out_o == '0 && type_out_o == '0))
    else $error("Nonzero handles on a result that is not a hit.");

  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == 2'(lpht_pkg::OP_UNUSED))
      |=> (done_o && status_o == 2'(lpht_pkg::ST_ABSENT)))
    else $error("Unused operation code was not answered as absent.");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
